// File: design/ssw_pkg.sv
// Shared constants, codes and types for the subset sum window search block.
`timescale 1ns / 1ps

package ssw_pkg;

   localparam int MAX_ITEMS   = 32;
   localparam int MAX_MATCHES = 63;
   localparam int AMT_W       = 24;
   localparam int MASK_W      = 32;
   localparam int SLOT_W      = 5;
   localparam int CNT_W       = 6;
   localparam int TGT_W       = 29;
   localparam int TOL_W       = 28;
   localparam int SUM_W       = 29;
   localparam int CELLS       = (MAX_ITEMS < MASK_W) ? MAX_ITEMS : MASK_W;
   localparam int ACC_W       = AMT_W + $clog2(CELLS) + 1;
   localparam int BND_W       = ((ACC_W > TGT_W + 1) ? ACC_W : TGT_W + 1) + 1;
   localparam int MCNT_W      = $clog2(MAX_MATCHES + 1);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ITEM_COUNT = 3'd0,
      CSR_TARGET     = 3'd1,
      CSR_TOLERANCE  = 3'd2,
      CSR_FIRST_MASK = 3'd3,
      CSR_LAST_MASK  = 3'd4
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_RUN  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CLOSE,
      ST_WAIT
   } seq_state_type;

   typedef struct packed {
      logic              valid;
      logic              close;
      logic [MASK_W-1:0] mask;
      logic [ACC_W-1:0]  sum;
   } chain_word_type;

   typedef struct packed {
      logic             start;
      logic [BND_W-1:0] lo;
      logic [BND_W-1:0] hi;
   } run_ctl_type;

endpackage

// File: design/ssw_cell.sv
// One cell of the summing chain: holds one amount, adds it to the passing word when take is set.
`timescale 1ns / 1ps

module ssw_cell import ssw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              load_en,
   input  logic [AMT_W-1:0]  load_value,
   input  logic              take,
   input  chain_word_type    prev_word,
   output chain_word_type    next_word
);

   logic [AMT_W-1:0] amount_ff;
   chain_word_type   word_ff;
   chain_word_type   word_in;
   logic [ACC_W-1:0] addend;

   always_ff @(posedge clock) begin
      if (load_en) begin
         amount_ff <= load_value;
      end
   end

   always_comb begin
      addend      = take ? ACC_W'($signed(amount_ff)) : '0;
      word_in     = prev_word;
      word_in.sum = prev_word.sum + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   assign next_word = word_ff;

endmodule

// File: design/ssw_seq.sv
// Mask sequencer: walks the mask window into the chain, then the closing word.
`timescale 1ns / 1ps

module ssw_seq import ssw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              run_go,
   input  logic              advance,
   input  logic              close_done,
   input  logic [TGT_W-1:0]  target,
   input  logic [TOL_W-1:0]  tolerance,
   input  logic [MASK_W-1:0] first_mask,
   input  logic [MASK_W-1:0] last_mask,
   output chain_word_type    inject,
   output run_ctl_type       ctl,
   output logic              busy
);

   seq_state_type     state_ff, state_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [BND_W-1:0]  lo_ff, lo_in;
   logic [BND_W-1:0]  hi_ff, hi_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      inject.valid = 1'b0;
      inject.close = 1'b0;
      inject.mask  = mask_ff;
      inject.sum   = '0;
      ctl.start    = 1'b0;
      ctl.lo       = lo_ff;
      ctl.hi       = hi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               ctl.start = 1'b1;
               mask_in   = first_mask;
               lo_in     = BND_W'($signed(target)) - BND_W'(tolerance);
               hi_in     = BND_W'($signed(target)) + BND_W'(tolerance);
               state_in  = (first_mask > last_mask) ? ST_CLOSE : ST_WALK;
            end
         end
         ST_WALK: begin
            inject.valid = 1'b1;
            if (advance) begin
               if (mask_ff == last_mask) begin
                  state_in = ST_CLOSE;
               end else begin
                  mask_in = mask_ff + 1'b1;
               end
            end
         end
         ST_CLOSE: begin
            inject.valid = 1'b1;
            inject.close = 1'b1;
            inject.mask  = '0;
            if (advance) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (close_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy   = (state_ff != ST_IDLE);

endmodule

// File: design/ssw_out.sv
// Result stage: window compare, match limit, saturation and output register.
`timescale 1ns / 1ps

module ssw_out import ssw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  chain_word_type    tail,
   input  run_ctl_type       ctl,
   input  logic              rsp_stall,
   output logic              advance,
   output logic              rsp_valid,
   output logic [MASK_W-1:0] rsp_subset_mask,
   output logic [SUM_W-1:0]  rsp_subset_sum,
   output logic              rsp_is_match,
   output logic              rsp_last,
   output logic              rsp_truncated
);

   logic              valid_ff, valid_in;
   logic [MCNT_W-1:0] count_ff, count_in;
   logic              trunc_ff, trunc_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              match_ff, match_in;
   logic              last_ff, last_in;
   logic              trunc_out_ff, trunc_out_in;

   logic [BND_W-1:0]       sum_ext;
   logic                   hit;
   logic                   room;
   logic [ACC_W-SUM_W:0]   upper;
   logic [SUM_W-1:0]       sum_sat;

   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      sum_ext = BND_W'($signed(tail.sum));
      hit     = tail.valid && !tail.close &&
                ($signed(sum_ext) >= $signed(ctl.lo)) &&
                ($signed(sum_ext) <= $signed(ctl.hi));
      room    = (count_ff < MCNT_W'(MAX_MATCHES));
      upper   = tail.sum[ACC_W-1:SUM_W-1];
      if ((&upper) || !(|upper)) begin
         sum_sat = tail.sum[SUM_W-1:0];
      end else if (tail.sum[ACC_W-1]) begin
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end

      count_in     = count_ff;
      trunc_in     = trunc_ff;
      valid_in     = valid_ff;
      mask_in      = mask_ff;
      sum_in       = sum_ff;
      match_in     = match_ff;
      last_in      = last_ff;
      trunc_out_in = trunc_out_ff;

      if (ctl.start) begin
         count_in = '0;
         trunc_in = 1'b0;
      end else if (advance) begin
         valid_in = 1'b0;
         if (tail.valid && tail.close) begin
            valid_in     = 1'b1;
            mask_in      = '0;
            sum_in       = '0;
            match_in     = 1'b0;
            last_in      = 1'b1;
            trunc_out_in = trunc_ff;
         end else if (hit && room) begin
            valid_in     = 1'b1;
            mask_in      = tail.mask;
            sum_in       = sum_sat;
            match_in     = 1'b1;
            last_in      = 1'b0;
            trunc_out_in = 1'b0;
            count_in     = count_ff + 1'b1;
         end else if (hit) begin
            trunc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         trunc_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         trunc_ff <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      sum_ff       <= sum_in;
      match_ff     <= match_in;
      last_ff      <= last_in;
      trunc_out_ff <= trunc_out_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_subset_mask = mask_ff;
   assign rsp_subset_sum  = sum_ff;
   assign rsp_is_match    = match_ff;
   assign rsp_last        = last_ff;
   assign rsp_truncated   = trunc_out_ff;

endmodule

// File: design/subset_sum_window_search_core.sv
// Top level of the subset sum window search: registers, sequencer, cell chain, result stage.
//
// Usage: load words (req_action = 0) write req_amount_value into table slot req_slot;
// loads may follow each other in every cycle while req_stall is low. A run word
// (req_action = 1) walks every mask from first_mask to last_mask through a chain of
// 32 summing cells, one mask entering the chain per cycle unless rsp_stall holds it. Each mask
// whose sum lies within tolerance of target, up to 63 of them, leaves on the rsp channel
// as a match word; the run ends with one closing word (rsp_last = 1, rsp_truncated set
// when more than 63 matches existed). A mask passes the register of each of the 32 chain
// cells and then the output register before its match word is presented. req_stall
// stays high from the run word until the closing word is taken; the next word can be
// taken in the cycle after that. Configuration is written through csr_we / csr_index /
// csr_data; the user must do so only while no run is in flight, which the block itself
// does not enforce. A synchronous reset clears the control state and restores the
// register defaults; the amount table holds no value until loaded. While rsp_stall is
// high with a word pending, the chain and sequencer hold.
`timescale 1ns / 1ps

module subset_sum_window_search_core import ssw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [AMT_W-1:0]      req_amount_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MASK_W-1:0]     rsp_subset_mask,
   output logic [SUM_W-1:0]      rsp_subset_sum,
   output logic                  rsp_is_match,
   output logic                  rsp_last,
   output logic                  rsp_truncated,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [CNT_W-1:0]  item_count_ff;
   logic [TGT_W-1:0]  target_ff;
   logic [TOL_W-1:0]  tolerance_ff;
   logic [MASK_W-1:0] first_mask_ff;
   logic [MASK_W-1:0] last_mask_ff;

   logic              busy;
   logic              advance;
   logic              load_go;
   logic              run_go;
   logic              close_done;
   logic [CNT_W-1:0]  n_eff;
   run_ctl_type       ctl;
   chain_word_type    chain [0:CELLS];
   logic [CELLS-1:0]  take;
   logic [CELLS-1:0]  load_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= CNT_W'(32);
         target_ff     <= '0;
         tolerance_ff  <= '0;
         first_mask_ff <= '0;
         last_mask_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ITEM_COUNT: item_count_ff <= csr_data[CNT_W-1:0];
            CSR_TARGET:     target_ff     <= csr_data[TGT_W-1:0];
            CSR_TOLERANCE:  tolerance_ff  <= csr_data[TOL_W-1:0];
            CSR_FIRST_MASK: first_mask_ff <= csr_data[MASK_W-1:0];
            CSR_LAST_MASK:  last_mask_ff  <= csr_data[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = busy;
   assign load_go    = req_valid && !busy && (req_action == ACT_LOAD);
   assign run_go     = req_valid && !busy && (req_action == ACT_RUN);
   assign close_done = rsp_valid && !rsp_stall && rsp_last;
   assign n_eff      = (item_count_ff > CNT_W'(CELLS)) ? CNT_W'(CELLS) : item_count_ff;

   ssw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .run_go     (run_go),
      .advance    (advance),
      .close_done (close_done),
      .target     (target_ff),
      .tolerance  (tolerance_ff),
      .first_mask (first_mask_ff),
      .last_mask  (last_mask_ff),
      .inject     (chain[0]),
      .ctl        (ctl),
      .busy       (busy)
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      assign take[i]    = chain[i].mask[i] && (CNT_W'(i) < n_eff);
      assign load_en[i] = load_go && (req_slot == SLOT_W'(i));

      ssw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .load_en    (load_en[i]),
         .load_value (req_amount_value),
         .take       (take[i]),
         .prev_word  (chain[i]),
         .next_word  (chain[i+1])
      );
   end

   ssw_out u_out (
      .clock           (clock),
      .reset           (reset),
      .tail            (chain[CELLS]),
      .ctl             (ctl),
      .rsp_stall       (rsp_stall),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_subset_mask (rsp_subset_mask),
      .rsp_subset_sum  (rsp_subset_sum),
      .rsp_is_match    (rsp_is_match),
      .rsp_last        (rsp_last),
      .rsp_truncated   (rsp_truncated)
   );

endmodule

// File: dv/ssw_window_check.sv
// Watcher that predicts and compares the result words of the subset sum window search core.
`timescale 1ns / 1ps

module ssw_window_check import ssw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_action,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [AMT_W-1:0]      req_amount_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [MASK_W-1:0]     rsp_subset_mask,
   input  logic [SUM_W-1:0]      rsp_subset_sum,
   input  logic                  rsp_is_match,
   input  logic                  rsp_last,
   input  logic                  rsp_truncated,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    words_due
);

   typedef struct {
      logic [MASK_W-1:0] mask;
      logic [SUM_W-1:0]  sum;
      logic              is_match;
      logic              last;
      logic              truncated;
   } subset_word_type;

   localparam longint SUM_MAX = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -(longint'(1) << (SUM_W - 1));

   logic signed [AMT_W-1:0] amounts [MAX_ITEMS];
   logic [CNT_W-1:0]        item_count;
   logic signed [TGT_W-1:0] target;
   logic [TOL_W-1:0]        tolerance;
   logic [MASK_W-1:0]       first_mask;
   logic [MASK_W-1:0]       last_mask;
   subset_word_type         found_words [$];
   subset_word_type         head;

   function automatic void walk_window();
      int unsigned     used;
      logic [MASK_W:0] m;
      longint          total;
      longint          gap;
      int              reported;
      logic            dropped;
      subset_word_type w;
      used = item_count;
      if (used > MAX_ITEMS) used = MAX_ITEMS;
      if (used > MASK_W) used = MASK_W;
      reported = 0;
      dropped = 1'b0;
      for (m = {1'b0, first_mask}; m <= {1'b0, last_mask}; m++) begin
         total = 0;
         for (int i = 0; i < used; i++)
            if (m[i]) total += longint'(amounts[i]);
         gap = total - longint'(target);
         if (gap < 0) gap = -gap;
         if (gap <= longint'(tolerance)) begin
            if (reported < MAX_MATCHES) begin
               if (total > SUM_MAX) total = SUM_MAX;
               if (total < SUM_MIN) total = SUM_MIN;
               w.mask = m[MASK_W-1:0];
               w.sum = total[SUM_W-1:0];
               w.is_match = 1'b1;
               w.last = 1'b0;
               w.truncated = 1'b0;
               found_words.push_back(w);
               reported++;
            end else begin
               dropped = 1'b1;
            end
         end
      end
      w.mask = '0;
      w.sum = '0;
      w.is_match = 1'b0;
      w.last = 1'b1;
      w.truncated = dropped;
      found_words.push_back(w);
   endfunction

   task automatic compare_field(input string field, input logic [MASK_W-1:0] want,
                                input logic [MASK_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         item_count = 6'd32;
         target = '0;
         tolerance = '0;
         first_mask = '0;
         last_mask = '0;
         found_words.delete();
         words_due <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ITEM_COUNT: item_count = csr_data[CNT_W-1:0];
               CSR_TARGET:     target = csr_data[TGT_W-1:0];
               CSR_TOLERANCE:  tolerance = csr_data[TOL_W-1:0];
               CSR_FIRST_MASK: first_mask = csr_data[MASK_W-1:0];
               CSR_LAST_MASK:  last_mask = csr_data[MASK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (found_words.size() == 0) begin
               $display("%0t: result word expected none actual mask %h sum %h last %b",
                        $time, rsp_subset_mask, rsp_subset_sum, rsp_last);
               mismatch_count++;
            end else begin
               head = found_words.pop_front();
               compare_field("subset_mask", head.mask, rsp_subset_mask);
               compare_field("subset_sum", head.sum, rsp_subset_sum);
               compare_field("is_match", head.is_match, rsp_is_match);
               compare_field("last", head.last, rsp_last);
               compare_field("truncated", head.truncated, rsp_truncated);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_LOAD) amounts[req_slot] = req_amount_value;
            else walk_window();
         end
         words_due <= found_words.size();
      end
   end

endmodule

// File: dv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the subset sum window search core.
`timescale 1ns / 1ps

module tb_top import ssw_pkg::*;;

   localparam int LATENCY  = 40;
   localparam int LIMIT    = 1000000;
   localparam int HOLD_LEN = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACT_LOAD;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic [AMT_W-1:0]      req_amount_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [MASK_W-1:0]     rsp_subset_mask;
   logic [SUM_W-1:0]      rsp_subset_sum;
   logic                  rsp_is_match;
   logic                  rsp_last;
   logic                  rsp_truncated;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatch_count;
   int words_due;
   int send_idle_pct = 15;
   int recv_idle_pct = 62;
   int hold_num = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   subset_sum_window_search_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_amount_value (req_amount_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_subset_mask  (rsp_subset_mask),
      .rsp_subset_sum   (rsp_subset_sum),
      .rsp_is_match     (rsp_is_match),
      .rsp_last         (rsp_last),
      .rsp_truncated    (rsp_truncated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   ssw_window_check subset_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_amount_value (req_amount_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_subset_mask  (rsp_subset_mask),
      .rsp_subset_sum   (rsp_subset_sum),
      .rsp_is_match     (rsp_is_match),
      .rsp_last         (rsp_last),
      .rsp_truncated    (rsp_truncated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .words_due        (words_due)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_seen != hold_num) begin
         hold_seen <= hold_num;
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [AMT_W-1:0] pick_amount();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 8) return 24'h7F_FFFF;
      if (sel < 15) return 24'h80_0000;
      if (sel < 60) return AMT_W'(int'($urandom_range(2000)) - 1000);
      return AMT_W'($urandom);
   endfunction

   task automatic send_word(input action_type act, input logic [SLOT_W-1:0] slot,
                            input logic [AMT_W-1:0] amount);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_slot <= slot;
      req_amount_value <= amount;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_run();
      send_word(ACT_RUN, SLOT_W'($urandom), AMT_W'($urandom));
   endtask

   // drop valid, drain every pending word, then let the chain empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic set_window(input int unsigned n, input int tgt, input int unsigned tol,
                             input logic [MASK_W-1:0] fm, input logic [MASK_W-1:0] lm);
      settle();
      write_reg(CSR_ITEM_COUNT, n);
      write_reg(CSR_TARGET, tgt);
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_FIRST_MASK, fm);
      write_reg(CSR_LAST_MASK, lm);
      csr_we <= 1'b0;
   endtask

   task automatic random_window();
      int unsigned       n;
      int unsigned       tol;
      int unsigned       width;
      int unsigned       sel;
      int                tgt;
      logic [MASK_W:0]   span;
      logic [63:0]       keep;
      logic [MASK_W-1:0] fm;
      logic [MASK_W-1:0] lm;
      sel = $urandom_range(99);
      if (sel < 80) n = $urandom_range(32, 2);
      else if (sel < 90) n = $urandom_range(1, 0);
      else n = $urandom_range(63, 33);
      sel = $urandom_range(99);
      if (sel < 60) tgt = int'($urandom_range(6000)) - 3000;
      else if (sel < 75) tgt = int'($urandom_range(536870911)) - 268435456;
      else if (sel < 80) tgt = -268435456;
      else if (sel < 85) tgt = 268435455;
      else tgt = 0;
      sel = $urandom_range(99);
      if (sel < 50) tol = $urandom_range(2000);
      else if (sel < 65) tol = 0;
      else if (sel < 75) tol = 268435455;
      else tol = $urandom_range(268435455);
      sel = $urandom_range(99);
      if (sel < 70) width = $urandom_range(40);
      else if (sel < 90) width = $urandom_range(300, 41);
      else width = 0;
      sel = $urandom_range(99);
      keep = (64'd1 << $urandom_range(32)) - 64'd1;
      if (sel < 60) fm = $urandom & keep[MASK_W-1:0];
      else if (sel < 75) fm = 32'hFFFF_FFFF - width;
      else fm = $urandom;
      span = {1'b0, fm} + width;
      lm = span[MASK_W] ? '1 : span[MASK_W-1:0];
      if ($urandom_range(99) < 6) begin
         lm = $urandom_range(1000);
         fm = lm + $urandom_range(1000, 1);
      end
      set_window(n, tgt, tol, fm, lm);
   endtask

   initial begin
      int unsigned items;
      int unsigned burst;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_word(ACT_LOAD, 5'd0, 24'h7F_FFFF);
      send_word(ACT_LOAD, 5'd1, 24'h80_0000);
      send_word(ACT_LOAD, 5'd2, 24'h00_0000);
      send_word(ACT_LOAD, 5'd3, 24'hFF_FFFF);
      send_word(ACT_LOAD, 5'd4, AMT_W'(100));
      send_word(ACT_LOAD, 5'd5, AMT_W'(-250));
      send_word(ACT_LOAD, 5'd6, AMT_W'(12345));
      send_word(ACT_LOAD, 5'd7, AMT_W'(-12345));
      send_word(ACT_LOAD, 5'd31, AMT_W'($urandom));
      set_window(8, 0, 0, 0, 255);
      send_run();
      set_window(8, 0, 268435455, 0, 255);
      send_run();
      set_window(8, 0, 0, 10, 9);
      send_run();
      set_window(8, 0, 0, 0, 0);
      send_run();
      set_window(0, 0, 0, 0, 15);
      send_run();
      set_window(1, 8388607, 0, 0, 3);
      send_run();
      set_window(8, -268435456, 268435455, 0, 63);
      send_run();
      set_window(8, 268435455, 0, 0, 255);
      send_run();
      set_window(8, 100, 50, 128, 191);
      send_run();

      for (int s = 0; s < MAX_ITEMS; s++) send_word(ACT_LOAD, SLOT_W'(s), pick_amount());

      for (int phase = 0; phase < 3; phase++) begin
         settle();
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 15 : 0;
         if (phase == 2) begin
            set_window(32, 0, 268435455, 32'h0000_1000, 32'h0000_1078);
            send_run();
            hold_num <= hold_num + 1;
            repeat (4) send_word(ACT_LOAD, SLOT_W'($urandom), pick_amount());
         end
         items = 0;
         while (items < 100) begin
            random_window();
            burst = $urandom_range(6, 1);
            repeat (burst) begin
               if ($urandom_range(99) < 40) send_run();
               else send_word(ACT_LOAD, SLOT_W'($urandom), pick_amount());
            end
            items += burst;
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
design/ssw_pkg.sv
design/ssw_cell.sv
design/ssw_seq.sv
design/ssw_out.sv
design/subset_sum_window_search_core.sv
dv/ssw_window_check.sv
dv/tb_top.sv
